// ----- design/lvpm_pkg.sv -----
package lvpm_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_INV_VOXEL_SIZE       = 2'd0;
	localparam logic [1:0] CFG_MAX_VOXELS           = 2'd1;
	localparam logic [1:0] CFG_MAX_POINTS_PER_VOXEL = 2'd2;

	// configuration reset values
	localparam logic [15:0] RST_INV_VOXEL_SIZE       = 16'd512;
	localparam logic [8:0]  RST_MAX_VOXELS           = 9'd256;
	localparam logic [4:0]  RST_MAX_POINTS_PER_VOXEL = 5'd16;

	// axis codes used by the quantiser
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic [7:0]         slot;
		logic               was_hit;
		logic               point_stored;
		logic [4:0]         points_in_voxel;
		logic signed [15:0] key_x;
		logic signed [15:0] key_y;
		logic signed [15:0] key_z;
		logic               evicted;
		logic signed [15:0] evicted_key_x;
		logic signed [15:0] evicted_key_y;
		logic signed [15:0] evicted_key_z;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic sat;
		logic scan_clear;
		logic step;
		logic upd;
		logic decide;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic axis_last;
		logic pass_done;
	} dp_status_t;

endpackage

// ----- design/lvpm_ctrl.sv -----
module lvpm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output lvpm_pkg::dp_cmd_t      cmd,
	input  lvpm_pkg::dp_status_t   status
);
	import lvpm_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_QMUL   = 3'd1;
	localparam logic [2:0] ST_QSAT   = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_UPD    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_QMUL;
				end
			end
			ST_QMUL: begin
				cmd.mul = 1'b1;
				state_d = ST_QSAT;
			end
			ST_QSAT: begin
				cmd.sat = 1'b1;
				if (status.axis_last) begin
					cmd.scan_clear = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					state_d = ST_QMUL;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.pass_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.step = 1'b1;
				cmd.upd  = 1'b1;
				if (status.pass_done) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- design/lvpm_dp.sv -----
module lvpm_dp #(
	parameter int CAPACITY         = 256,
	parameter int POINTS_PER_VOXEL = 16,
	parameter int KEY_BITS         = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lvpm_pkg::dp_cmd_t      cmd,
	output lvpm_pkg::dp_status_t   status,
	input  lvpm_pkg::point_t       point,
	input  logic [15:0]            inv_voxel_size,
	input  logic [8:0]             max_voxels,
	input  logic [4:0]             max_points_per_voxel,
	output lvpm_pkg::result_t      result,
	output logic                   done
);
	import lvpm_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int CW   = $clog2(POINTS_PER_VOXEL + 1);
	localparam int PAW  = $clog2(CAPACITY * POINTS_PER_VOXEL);
	localparam int KW   = 3 * KEY_BITS;
	localparam logic signed [24:0] KEY_MAX = 25'((2 ** (KEY_BITS - 1)) - 1);
	localparam logic signed [24:0] KEY_MIN = -KEY_MAX - 25'sd1;

	// item registers
	point_t                     pt_q;
	logic [1:0]                 axis_q;
	logic signed [48:0]         prod_q;
	logic signed [KEY_BITS-1:0] kx_q, ky_q, kz_q;

	// table storage
	logic [KW-1:0]   key_mem  [CAPACITY];
	logic [AW-1:0]   rank_mem [CAPACITY];
	logic [CW-1:0]   cnt_mem  [CAPACITY];
	point_t          pt_mem   [CAPACITY * POINTS_PER_VOXEL];
	logic [CAPACITY-1:0] valid_q;
	logic [CNTW-1:0] vox_use_q;

	// slot walk
	logic [CNTW-1:0] cnt_q;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   addr_s1;
	logic            vld_s1;
	logic [KW-1:0]   key_rd_s1;
	logic [AW-1:0]   rank_rd_s1;
	logic [CW-1:0]   cnt_rd_s1;

	// scan findings
	logic            hit_q;
	logic [AW-1:0]   hit_slot_q;
	logic [AW-1:0]   hit_rank_q;
	logic [CW-1:0]   hit_cnt_q;
	logic [AW-1:0]   lru_slot_q;
	logic [KW-1:0]   lru_key_q;
	logic            free_found_q;
	logic [AW-1:0]   free_slot_q;

	// decision registers
	logic [AW-1:0]   tgt_q;
	logic            stored_q;
	logic            ev_q;
	logic [CW-1:0]   newcnt_q;
	result_t         res_q;
	logic            done_q;

	logic signed [31:0]         mul_a;
	logic signed [24:0]         quo;
	logic signed [KEY_BITS-1:0] sat_key;
	logic [KW-1:0]              cur_key;
	logic [CNTW-1:0]            lim_v;
	logic [CW-1:0]              lim_p;
	logic                       evict_c;
	logic                       stored_c;
	logic [AW-1:0]              tgt_c;
	logic [CW-1:0]              base_c;
	logic [CW-1:0]              newcnt_c;
	logic [PAW-1:0]             pt_idx;
	logic [AW-1:0]              rank_new;
	logic                       cnt_live;

	// multiplier operand per axis
	always_comb begin
		case (axis_q)
			AXIS_X:  mul_a = pt_q.point_x;
			AXIS_Y:  mul_a = pt_q.point_y;
			AXIS_Z:  mul_a = pt_q.point_z;
			default: mul_a = pt_q.point_z;
		endcase
	end

	// floor by arithmetic shift, then saturate
	assign quo = 25'(prod_q >>> 24);
	always_comb begin
		if (quo > KEY_MAX) begin
			sat_key = KEY_MAX[KEY_BITS-1:0];
		end else if (quo < KEY_MIN) begin
			sat_key = KEY_MIN[KEY_BITS-1:0];
		end else begin
			sat_key = quo[KEY_BITS-1:0];
		end
	end

	assign cur_key = {kx_q, ky_q, kz_q};

	// limits clamped between one and the table size
	always_comb begin
		if (max_voxels == 9'd0) begin
			lim_v = CNTW'(1);
		end else if (int'(max_voxels) > CAPACITY) begin
			lim_v = CNTW'(CAPACITY);
		end else begin
			lim_v = CNTW'(max_voxels);
		end
		if (max_points_per_voxel == 5'd0) begin
			lim_p = CW'(1);
		end else if (int'(max_points_per_voxel) > POINTS_PER_VOXEL) begin
			lim_p = CW'(POINTS_PER_VOXEL);
		end else begin
			lim_p = CW'(max_points_per_voxel);
		end
	end

	// hit, eviction or fresh slot
	always_comb begin
		evict_c  = !hit_q && (vox_use_q >= lim_v);
		tgt_c    = hit_q ? hit_slot_q : (evict_c ? lru_slot_q : free_slot_q);
		stored_c = hit_q ? (hit_cnt_q < lim_p) : 1'b1;
		base_c   = hit_q ? hit_cnt_q : '0;
		newcnt_c = stored_c ? CW'(base_c + CW'(1)) : base_c;
		pt_idx   = PAW'(PAW'(tgt_c) * PAW'(POINTS_PER_VOXEL)) + PAW'(base_c);
	end

	// recency for the slot under update
	always_comb begin
		if (addr_s1 == tgt_q) begin
			rank_new = '0;
		end else if (valid_q[addr_s1] && (!hit_q || rank_rd_s1 < hit_rank_q)) begin
			rank_new = AW'(rank_rd_s1 + AW'(1));
		end else begin
			rank_new = rank_rd_s1;
		end
	end

	assign cnt_live = (cnt_q != CNTW'(CAPACITY));
	assign rd_addr  = cnt_q[AW-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q    <= AXIS_X;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			valid_q   <= '0;
			vox_use_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				axis_q <= AXIS_X;
			end else if (cmd.sat) begin
				axis_q <= axis_q + 2'd1;
			end
			if (cmd.scan_clear || cmd.decide) begin
				cnt_q <= '0;
			end else if (cmd.step && cnt_live) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			vld_s1 <= cmd.step && cnt_live;
			if (cmd.decide) begin
				valid_q[tgt_c] <= 1'b1;
				if (!hit_q && !evict_c) begin
					vox_use_q <= vox_use_q + CNTW'(1);
				end
			end
		end
	end

	// quantiser
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pt_q <= point;
		end
		if (cmd.mul) begin
			prod_q <= mul_a * $signed({1'b0, inv_voxel_size});
		end
		if (cmd.sat) begin
			case (axis_q)
				AXIS_X:  kx_q <= sat_key;
				AXIS_Y:  ky_q <= sat_key;
				default: kz_q <= sat_key;
			endcase
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		key_rd_s1  <= key_mem[rd_addr];
		rank_rd_s1 <= rank_mem[rd_addr];
		cnt_rd_s1  <= cnt_mem[rd_addr];
		addr_s1    <= rd_addr;
		if (cmd.decide) begin
			key_mem[tgt_c] <= cur_key;
			cnt_mem[tgt_c] <= newcnt_c;
			if (stored_c) begin
				pt_mem[pt_idx] <= pt_q;
			end
		end
		if (cmd.upd && vld_s1) begin
			rank_mem[addr_s1] <= rank_new;
		end
	end

	// scan over the slots
	always_ff @(posedge clk) begin
		if (cmd.scan_clear) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			hit_slot_q   <= '0;
			hit_rank_q   <= '0;
			hit_cnt_q    <= '0;
			lru_slot_q   <= '0;
			lru_key_q    <= '0;
			free_slot_q  <= '0;
		end else if (cmd.step && !cmd.upd && vld_s1) begin
			if (valid_q[addr_s1]) begin
				if (!hit_q && key_rd_s1 == cur_key) begin
					hit_q      <= 1'b1;
					hit_slot_q <= addr_s1;
					hit_rank_q <= rank_rd_s1;
					hit_cnt_q  <= cnt_rd_s1;
				end
				if (rank_rd_s1 == AW'(vox_use_q - CNTW'(1))) begin
					lru_slot_q <= addr_s1;
					lru_key_q  <= key_rd_s1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= addr_s1;
			end
		end
	end

	// decision and result
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			tgt_q    <= tgt_c;
			stored_q <= stored_c;
			ev_q     <= evict_c;
			newcnt_q <= newcnt_c;
		end
		if (cmd.finish) begin
			res_q.slot            <= 8'(tgt_q);
			res_q.was_hit         <= hit_q;
			res_q.point_stored    <= stored_q;
			res_q.points_in_voxel <= 5'(newcnt_q);
			res_q.key_x           <= 16'(kx_q);
			res_q.key_y           <= 16'(ky_q);
			res_q.key_z           <= 16'(kz_q);
			res_q.evicted         <= ev_q;
			res_q.evicted_key_x   <= ev_q ?
				16'($signed(lru_key_q[KW-1 -: KEY_BITS])) : '0;
			res_q.evicted_key_y   <= ev_q ?
				16'($signed(lru_key_q[2*KEY_BITS-1 -: KEY_BITS])) : '0;
			res_q.evicted_key_z   <= ev_q ?
				16'($signed(lru_key_q[KEY_BITS-1:0])) : '0;
		end
	end

	assign status.axis_last = (axis_q == AXIS_Z);
	assign status.pass_done = !cnt_live && !vld_s1;
	assign result = res_q;
	assign done   = done_q;

endmodule

// ----- design/lru_voxel_point_map.sv -----
// channel   | ports                           | transfer
// ----------+---------------------------------+-------------------------------
// point in  | start, busy, point              | start high while busy low
// result    | done, result                    | done high for one cycle
// config    | cfg_we, cfg_index, cfg_wdata    | cfg_we high, no wait
//
// busy stays high from the accepting edge until the work is through, and done
// follows in the next cycle: quantising (one shared multiplier, three axes, a
// multiply and a saturate state per axis), a pass over the slot memories for key
// search and LRU lookup, a decision state and a second pass that rewrites the
// recency ranks; each pass reads one slot per cycle through a registered read.
// reset clears the valid bits and the voxel count; no clearing pass is needed.
// results cannot be stalled; busy drops in the cycle that done is high.
module lru_voxel_point_map #(
	parameter int CAPACITY         = 256,
	parameter int POINTS_PER_VOXEL = 16,
	parameter int KEY_BITS         = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lvpm_pkg::point_t  point,
	output logic              done,
	output lvpm_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);
	import lvpm_pkg::*;

	logic [15:0] inv_voxel_size_q;
	logic [8:0]  max_voxels_q;
	logic [4:0]  max_points_q;
	dp_cmd_t     cmd;
	dp_status_t  status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_voxel_size_q <= RST_INV_VOXEL_SIZE;
			max_voxels_q     <= RST_MAX_VOXELS;
			max_points_q     <= RST_MAX_POINTS_PER_VOXEL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INV_VOXEL_SIZE:       inv_voxel_size_q <= cfg_wdata;
				CFG_MAX_VOXELS:           max_voxels_q     <= cfg_wdata[8:0];
				CFG_MAX_POINTS_PER_VOXEL: max_points_q     <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	lvpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	lvpm_dp #(
		.CAPACITY         (CAPACITY),
		.POINTS_PER_VOXEL (POINTS_PER_VOXEL),
		.KEY_BITS         (KEY_BITS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.point                (point),
		.inv_voxel_size       (inv_voxel_size_q),
		.max_voxels           (max_voxels_q),
		.max_points_per_voxel (max_points_q),
		.result               (result),
		.done                 (done)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("accepted point not busy");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.points_in_voxel != 5'd0) else $error("empty voxel reported");
	a_miss_stores: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.was_hit |-> result.point_stored &&
		result.points_in_voxel == 5'd1) else $error("new voxel without its point");
	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.was_hit || !result.evicted) |-> result.evicted_key_x == 16'sd0 &&
		result.evicted_key_y == 16'sd0 && result.evicted_key_z == 16'sd0)
		else $error("evicted key without eviction");
`endif

endmodule
